@@ rtl/core/mfap_pkg.sv @@
// Shared constants and types for the max-flow augmenting path unit.
package mfap_pkg;

    localparam int MaxVertices = 64;
    localparam int VtxW        = $clog2(MaxVertices);
    localparam int AddrW       = 2 * VtxW;
    localparam int Entries     = MaxVertices * MaxVertices;
    localparam int CntW        = VtxW + 1;
    localparam int FieldW      = 7;
    localparam int CapW        = 16;
    localparam int ResW        = 32;
    localparam int FlowW       = 38;

    localparam logic [ResW-1:0] EntryMax = {ResW{1'b1}};

    // Register addresses (byte address bits [3:2]).
    localparam logic [1:0] RegVertexCount = 2'd0;
    localparam logic [1:0] RegSourceVertex = 2'd1;
    localparam logic [1:0] RegSinkVertex   = 2'd2;

    // Edge request payload.
    typedef struct packed {
        logic [FieldW-1:0] from_vertex;
        logic [FieldW-1:0] to_vertex;
        logic [CapW-1:0]   edge_capacity;
        logic              last_edge;
    } edge_req_t;

    // Result payload.
    typedef struct packed {
        logic [FlowW-1:0] max_flow;
    } flow_rsp_t;

    // Saturating add of two residual entries.
    function automatic logic [ResW-1:0] sat_add(input logic [ResW-1:0] a,
                                                input logic [ResW-1:0] b);
        logic [ResW:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[ResW] ? EntryMax : s[ResW-1:0];
        end
    endfunction

endpackage

@@ rtl/core/mfap_if.sv @@
// Valid/ready channel interfaces for edge requests and flow results.
interface mfap_edge_if;
    import mfap_pkg::*;
    logic      valid;
    logic      ready;
    edge_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mfap_flow_if;
    import mfap_pkg::*;
    logic      valid;
    logic      ready;
    flow_rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/mfap_res_mem.sv @@
// Residual capacity matrix: one write port, one registered read port.
module mfap_res_mem (
    input  logic                         clk,
    input  logic                         we,
    input  logic [mfap_pkg::AddrW-1:0]   waddr,
    input  logic [mfap_pkg::ResW-1:0]    wdata,
    input  logic [mfap_pkg::AddrW-1:0]   raddr,
    output logic [mfap_pkg::ResW-1:0]    rdata
);
    import mfap_pkg::*;

    logic [ResW-1:0] mem [Entries];

    // Synchronous write and read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/core/mfap_cfg.sv @@
// APB register file holding vertex count, source and sink.
module mfap_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [mfap_pkg::FieldW-1:0]   vertex_count,
    output logic [mfap_pkg::FieldW-1:0]   source_vertex,
    output logic [mfap_pkg::FieldW-1:0]   sink_vertex
);
    import mfap_pkg::*;

    logic [FieldW-1:0] count_reg;
    logic [FieldW-1:0] src_reg;
    logic [FieldW-1:0] snk_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes; the byte offset within a word is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= FieldW'(64);
            src_reg   <= FieldW'(1);
            snk_reg   <= FieldW'(64);
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                RegVertexCount: count_reg <= pwdata[FieldW-1:0];
                RegSourceVertex: src_reg <= pwdata[FieldW-1:0];
                RegSinkVertex: snk_reg <= pwdata[FieldW-1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            RegVertexCount: prdata = {25'd0, count_reg};
            RegSourceVertex: prdata = {25'd0, src_reg};
            RegSinkVertex: prdata = {25'd0, snk_reg};
            default: prdata = '0;
        endcase
    end

    assign vertex_count  = count_reg;
    assign source_vertex = src_reg;
    assign sink_vertex   = snk_reg;
endmodule

@@ rtl/core/mfap_ctrl.sv @@
// Sequencer: edge loading, DFS path search, augmentation and matrix clear.
module mfap_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mfap_pkg::FieldW-1:0]   vertex_count,
    input  logic [mfap_pkg::FieldW-1:0]   source_vertex,
    input  logic [mfap_pkg::FieldW-1:0]   sink_vertex,
    mfap_edge_if.sink                     edge_in,
    mfap_flow_if.source                   flow_out
);
    import mfap_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_LOADRD  = 11'b00000000100,
        S_LOADWR  = 11'b00000001000,
        S_INIT    = 11'b00000010000,
        S_POP     = 11'b00000100000,
        S_SCAN    = 11'b00001000000,
        S_BNECK   = 11'b00010000000,
        S_AUGF    = 11'b00100000000,
        S_AUGB    = 11'b01000000000,
        S_DONE    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Matrix memory port signals.
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr, mem_raddr;
    logic [ResW-1:0]  mem_wdata, mem_rdata;

    mfap_res_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Search state: visited bits in flops, parent and stack in small arrays.
    logic [MaxVertices-1:0] visited_reg;
    logic [VtxW-1:0]        parent_mem [MaxVertices];
    logic [VtxW-1:0]        stack_mem [MaxVertices];
    logic [CntW-1:0]        depth_reg;
    logic [VtxW-1:0]        u_reg;
    logic [CntW-1:0]        v_reg;
    logic                   rvalid_reg;
    logic [VtxW-1:0]        cur_reg;
    logic [VtxW-1:0]        par_reg;
    logic [ResW-1:0]        bneck_reg;
    logic [FlowW-1:0]       total_reg;
    logic [AddrW:0]         clr_reg;
    logic                   last_reg;
    edge_req_t              req_reg;
    logic [FlowW-1:0]       out_reg;
    logic                   out_valid_reg;

    // Active vertex count and terminal checks.
    logic [CntW:0]    n_act;
    logic             term_ok;
    logic [VtxW-1:0]  s_idx, t_idx;
    logic             edge_ok;
    logic             out_free;

    always_comb
    begin
        n_act = (vertex_count > FieldW'(MaxVertices)) ? (CntW+1)'(MaxVertices)
                                                      : (CntW+1)'(vertex_count);
        term_ok = source_vertex >= 1 && (CntW+1)'(source_vertex) <= n_act &&
                  sink_vertex >= 1 && (CntW+1)'(sink_vertex) <= n_act &&
                  source_vertex != sink_vertex;
        s_idx = VtxW'(source_vertex - 1'b1);
        t_idx = VtxW'(sink_vertex - 1'b1);
        edge_ok = req_reg.from_vertex >= 1 && (CntW+1)'(req_reg.from_vertex) <= n_act &&
                  req_reg.to_vertex >= 1 && (CntW+1)'(req_reg.to_vertex) <= n_act;
    end

    // The result register can take a new flow once the previous one is gone.
    assign out_free = !out_valid_reg || flow_out.ready;

    assign edge_in.ready = (state_reg == S_IDLE);
    assign flow_out.valid = out_valid_reg;
    assign flow_out.payload.max_flow = out_reg;

    // Scan-candidate vertex currently returned from memory.
    logic [VtxW-1:0] v_prev;
    logic            scan_hit;
    assign v_prev   = VtxW'(v_reg - 1'b1);
    assign scan_hit = rvalid_reg && !visited_reg[v_prev] && mem_rdata != '0;

    // Memory address and write control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AddrW-1:0];
            end
            S_LOADRD:
            begin
                mem_raddr = {VtxW'(req_reg.from_vertex - 1'b1),
                             VtxW'(req_reg.to_vertex - 1'b1)};
            end
            S_LOADWR:
            begin
                mem_we    = edge_ok;
                mem_waddr = {VtxW'(req_reg.from_vertex - 1'b1),
                             VtxW'(req_reg.to_vertex - 1'b1)};
                mem_wdata = sat_add(mem_rdata, {16'd0, req_reg.edge_capacity});
            end
            S_SCAN:
            begin
                mem_raddr = {u_reg, v_reg[VtxW-1:0]};
            end
            S_BNECK, S_AUGF:
            begin
                mem_raddr = {par_reg, cur_reg};
                if (state_reg == S_AUGF && rvalid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {par_reg, cur_reg};
                    mem_wdata = mem_rdata - bneck_reg;
                end
            end
            S_AUGB:
            begin
                mem_raddr = {cur_reg, par_reg};
                if (rvalid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {cur_reg, par_reg};
                    mem_wdata = sat_add(mem_rdata, bneck_reg);
                end
            end
            default: ;
        endcase
    end

    // Parent and stack array writes.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
        begin
            stack_mem[0]      <= s_idx;
            parent_mem[s_idx] <= s_idx;
        end
        else if (state_reg == S_SCAN && scan_hit)
        begin
            parent_mem[v_prev] <= u_reg;
            stack_mem[depth_reg[VtxW-1:0]] <= v_prev;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_reg == (AddrW+1)'(Entries - 1)) state_next = S_IDLE;
            S_IDLE: if (edge_in.valid) state_next = S_LOADRD;
            S_LOADRD: state_next = S_LOADWR;
            S_LOADWR:
            begin
                if (last_reg) state_next = term_ok ? S_INIT : S_DONE;
                else state_next = S_IDLE;
            end
            S_INIT: state_next = S_POP;
            S_POP: state_next = (depth_reg == '0) ? S_DONE : S_SCAN;
            S_SCAN:
            begin
                if (scan_hit && v_prev == t_idx) state_next = S_BNECK;
                else if ((CntW+1)'(v_reg) == n_act + 1'b1 ||
                         (!rvalid_reg && (CntW+1)'(v_reg) == n_act)) state_next = S_POP;
            end
            S_BNECK: if (rvalid_reg && par_reg == s_idx) state_next = S_AUGF;
            S_AUGF: if (rvalid_reg) state_next = S_AUGB;
            S_AUGB: if (rvalid_reg) state_next = (par_reg == s_idx) ? S_INIT : S_AUGF;
            S_DONE: if (out_free) state_next = S_CLEAR;
            default: state_next = S_CLEAR;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            rvalid_reg    <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Result register: loaded at the end of a solve, freed on acceptance.
            if (state_reg == S_DONE && out_free)
            begin
                out_reg       <= total_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && flow_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (edge_in.valid)
                    begin
                        req_reg  <= edge_in.payload;
                        last_reg <= edge_in.payload.last_edge;
                    end
                    total_reg <= '0;
                end
                S_INIT:
                begin
                    visited_reg <= {{(MaxVertices-1){1'b0}}, 1'b1} << s_idx;
                    depth_reg   <= CntW'(1);
                end
                S_POP:
                begin
                    if (depth_reg != '0)
                    begin
                        u_reg     <= stack_mem[VtxW'(depth_reg - 1'b1)];
                        depth_reg <= depth_reg - 1'b1;
                        v_reg     <= '0;
                        rvalid_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    rvalid_reg <= !(scan_hit && v_prev == t_idx);
                    v_reg      <= v_reg + 1'b1;
                    if (scan_hit)
                    begin
                        visited_reg[v_prev] <= 1'b1;
                        if (depth_reg < CntW'(MaxVertices))
                        begin
                            depth_reg <= depth_reg + 1'b1;
                        end
                        if (v_prev == t_idx)
                        begin
                            cur_reg    <= t_idx;
                            par_reg    <= u_reg;
                            bneck_reg  <= EntryMax;
                        end
                    end
                end
                S_BNECK:
                begin
                    rvalid_reg <= !rvalid_reg;
                    if (rvalid_reg)
                    begin
                        if (mem_rdata < bneck_reg) bneck_reg <= mem_rdata;
                        if (par_reg == s_idx)
                        begin
                            cur_reg <= t_idx;
                            par_reg <= parent_mem[t_idx];
                        end
                        else
                        begin
                            cur_reg <= par_reg;
                            par_reg <= parent_mem[par_reg];
                        end
                    end
                end
                S_AUGF:
                begin
                    rvalid_reg <= !rvalid_reg;
                end
                S_AUGB:
                begin
                    rvalid_reg <= !rvalid_reg;
                    if (rvalid_reg)
                    begin
                        cur_reg <= par_reg;
                        par_reg <= parent_mem[par_reg];
                        if (par_reg == s_idx)
                        begin
                            total_reg <= total_reg + FlowW'(bneck_reg);
                        end
                    end
                end
                S_DONE:
                begin
                    clr_reg <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

@@ rtl/core/max_flow_augmenting_paths_unit.sv @@
// Top level of the max-flow augmenting path unit.
// Edges arrive one request at a time; each is accepted, then its residual
// matrix entry is read, then added to and written back (the matrix lives in
// one 4096-entry synchronous RAM). After the request marked last, the unit
// runs depth-first searches from source to sink if both are valid; each popped
// vertex takes a pop step and then a scan of its row, one matrix entry read
// per cycle, and each path takes a setup step plus, per edge, steps to find the
// bottleneck and update both directions. The total flow is then placed in the
// result register, waiting first for any earlier result there to be taken,
// and the matrix is cleared, one entry per cycle, which also runs after reset.
// No edge is taken during a solve or the clear, but edges of the next graph
// load while a result waits.
module max_flow_augmenting_paths_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mfap_edge_if.sink   edge_in,
    mfap_flow_if.source flow_out
);
    import mfap_pkg::*;

    logic [FieldW-1:0] vertex_count, source_vertex, sink_vertex;

    mfap_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .vertex_count  (vertex_count),
        .source_vertex (source_vertex),
        .sink_vertex   (sink_vertex)
    );

    mfap_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .vertex_count  (vertex_count),
        .source_vertex (source_vertex),
        .sink_vertex   (sink_vertex),
        .edge_in       (edge_in),
        .flow_out      (flow_out)
    );
endmodule
